### rtl/core/cip_pkg.sv
// Shared types, constants and the sequencer control store for the color-ID pick search.
package cip_pkg;

    // Default geometry
    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int DEF_PICK_SIZE  = 5;

    // Field widths
    localparam int POS_W      = 9;
    localparam int ID_W       = 24;
    localparam int HIT_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int MODE_W     = 2;
    // Signed search coordinate: mouse position plus or minus the pick window
    localparam int COORD_W    = 11;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_MODE    = 2'd2;

    // Register reset values
    localparam logic [POS_W-1:0]  RST_FRAME_WIDTH  = 9'd256;
    localparam logic [POS_W-1:0]  RST_FRAME_HEIGHT = 9'd256;
    localparam logic [MODE_W-1:0] MODE_LR          = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SPIRAL      = 2'd1;

    // Item opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_PICK  = 1'b1;

    // Control store
    localparam int STEP_W = 4;

    typedef enum logic [2:0] {
        ACT_NOP,
        ACT_ORG_FWD,   // point = mouse, window base row = mouse row
        ACT_ORG_BWD,   // point = mouse - P on both axes
        ACT_ORG_SPI,   // point = mouse, heading +x, segment length one
        ACT_WIN,       // read point, step down the window column-major
        ACT_SPI,       // read point, take one spiral step
        ACT_ONE,       // read point once
        ACT_MISS       // report not found and finish
    } t_act;

    typedef enum logic [2:0] {
        JMP_NEXT,      // step + 1
        JMP_LOOP,      // stay until the point count is spent, then step + 1
        JMP_GOTO,      // go to target
        JMP_MODE,      // branch on scan mode
        JMP_END        // hold, sequence finishes through the action
    } t_jmp;

    typedef struct packed {
        t_act              act;
        t_jmp              jmp;
        logic [STEP_W-1:0] target;
    } t_uword;

    // Program labels
    localparam logic [STEP_W-1:0] ST_DISPATCH = 4'd0;
    localparam logic [STEP_W-1:0] ST_LR_ORG_F = 4'd1;
    localparam logic [STEP_W-1:0] ST_LR_WIN_F = 4'd2;
    localparam logic [STEP_W-1:0] ST_LR_ORG_B = 4'd3;
    localparam logic [STEP_W-1:0] ST_LR_WIN_B = 4'd4;
    localparam logic [STEP_W-1:0] ST_DRAIN    = 4'd5;
    localparam logic [STEP_W-1:0] ST_MISS     = 4'd6;
    localparam logic [STEP_W-1:0] ST_SP_ORG   = 4'd7;
    localparam logic [STEP_W-1:0] ST_SP_SCAN  = 4'd8;
    localparam logic [STEP_W-1:0] ST_TAIL     = 4'd9;
    localparam logic [STEP_W-1:0] ST_ONE_ORG  = 4'd10;
    localparam logic [STEP_W-1:0] ST_ONE_READ = 4'd11;

    // Microprogram. A drain or tail step separates the last read from the miss step.
    function automatic t_uword uc_rom(input logic [STEP_W-1:0] step);
        t_uword w;
        begin
            w = '{act: ACT_MISS, jmp: JMP_END, target: ST_DISPATCH};
            case (step)
                ST_DISPATCH: w = '{act: ACT_NOP,     jmp: JMP_MODE, target: ST_DISPATCH};
                ST_LR_ORG_F: w = '{act: ACT_ORG_FWD, jmp: JMP_NEXT, target: ST_DISPATCH};
                ST_LR_WIN_F: w = '{act: ACT_WIN,     jmp: JMP_LOOP, target: ST_DISPATCH};
                ST_LR_ORG_B: w = '{act: ACT_ORG_BWD, jmp: JMP_NEXT, target: ST_DISPATCH};
                ST_LR_WIN_B: w = '{act: ACT_WIN,     jmp: JMP_LOOP, target: ST_DISPATCH};
                ST_DRAIN:    w = '{act: ACT_NOP,     jmp: JMP_NEXT, target: ST_DISPATCH};
                ST_MISS:     w = '{act: ACT_MISS,    jmp: JMP_END,  target: ST_DISPATCH};
                ST_SP_ORG:   w = '{act: ACT_ORG_SPI, jmp: JMP_NEXT, target: ST_DISPATCH};
                ST_SP_SCAN:  w = '{act: ACT_SPI,     jmp: JMP_LOOP, target: ST_DISPATCH};
                ST_TAIL:     w = '{act: ACT_NOP,     jmp: JMP_GOTO, target: ST_MISS};
                ST_ONE_ORG:  w = '{act: ACT_ORG_FWD, jmp: JMP_NEXT, target: ST_DISPATCH};
                ST_ONE_READ: w = '{act: ACT_ONE,     jmp: JMP_GOTO, target: ST_TAIL};
                default:     w = '{act: ACT_MISS,    jmp: JMP_END,  target: ST_DISPATCH};
            endcase
            return w;
        end
    endfunction

    // Entry point of the program for a scan mode; the unused codes run single pixel
    function automatic logic [STEP_W-1:0] mode_entry(input logic [MODE_W-1:0] mode);
        logic [STEP_W-1:0] s;
        begin
            case (mode)
                MODE_LR:     s = ST_LR_ORG_F;
                MODE_SPIRAL: s = ST_SP_ORG;
                default:     s = ST_ONE_ORG;
            endcase
            return s;
        end
    endfunction

endpackage

### rtl/core/color_id_pick_search.sv
// Color-ID pick search top level: config registers, microcoded sequencer, search datapath.
// A write word is taken while idle (busy stays low) and is registered before it reaches the store.
// A pick word raises busy; the result strobe follows when a point read hits, else when the
// program reaches its miss step after the spiral, left-right or single-pixel scan.
// One store read per point, through a read pipeline of address and read-data stages.
// Synchronous active-low reset clears the sequencer and restores the register defaults.
module color_id_pick_search #(
    parameter int MAX_WIDTH  = cip_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = cip_pkg::DEF_MAX_HEIGHT,
    parameter int PICK_SIZE  = cip_pkg::DEF_PICK_SIZE
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Command channel
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_op,
    input  logic [cip_pkg::POS_W-1:0]      i_pos_x,
    input  logic [cip_pkg::POS_W-1:0]      i_pos_y,
    input  logic [cip_pkg::ID_W-1:0]       i_pixel_id,
    // Result channel
    output logic                           o_valid,
    output logic                           o_found,
    output logic [cip_pkg::ID_W-1:0]       o_hit_id,
    output logic [cip_pkg::HIT_W-1:0]      o_hit_x,
    output logic [cip_pkg::HIT_W-1:0]      o_hit_y,
    // Config write port
    input  logic                           i_cfg_we,
    input  logic [cip_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cip_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import cip_pkg::*;

    localparam int DEPTH    = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW       = $clog2(DEPTH);
    localparam int MW       = AW + COORD_W;
    localparam int CNTW     = $clog2(PICK_SIZE * PICK_SIZE + 1);
    localparam int OYW      = $clog2(PICK_SIZE + 1);
    localparam int SEGW     = $clog2(PICK_SIZE + 2) + 1;
    localparam logic [CNTW-1:0] LAST_CNT = CNTW'(PICK_SIZE * PICK_SIZE - 1);
    localparam logic [OYW-1:0]  LAST_OY  = OYW'(PICK_SIZE - 1);

    // Config registers
    logic [POS_W-1:0]  r_frame_w;
    logic [POS_W-1:0]  r_frame_h;
    logic [MODE_W-1:0] r_mode;

    // Sequencer and point generator
    logic                 r_busy,  n_busy;
    logic [STEP_W-1:0]    r_step,  n_step;
    logic [POS_W-1:0]     r_mx,    n_mx;
    logic [POS_W-1:0]     r_my,    n_my;
    logic [POS_W-1:0]     r_eff_w, n_eff_w;
    logic [POS_W-1:0]     r_eff_h, n_eff_h;
    logic [COORD_W-1:0]   r_px,    n_px;
    logic [COORD_W-1:0]   r_py,    n_py;
    logic [COORD_W-1:0]   r_by,    n_by;
    logic [OYW-1:0]       r_oy,    n_oy;
    logic [CNTW-1:0]      r_cnt,   n_cnt;
    logic [1:0]           r_dx,    n_dx;
    logic [1:0]           r_dy,    n_dy;
    logic [SEGW-1:0]      r_seg,   n_seg;
    logic [SEGW-1:0]      r_done,  n_done;

    // Read pipeline: stage a holds the address, stage b the read data
    logic                 r_a_v;
    logic                 r_a_inb;
    logic [AW-1:0]        r_a_addr;
    logic [HIT_W-1:0]     r_a_x;
    logic [HIT_W-1:0]     r_a_y;
    logic                 r_b_v;
    logic                 r_b_inb;
    logic [HIT_W-1:0]     r_b_x;
    logic [HIT_W-1:0]     r_b_y;
    logic [ID_W-1:0]      rd_data;

    // Pending store write
    logic                 r_wr_v;
    logic [AW-1:0]        r_wr_addr;
    logic [ID_W-1:0]      r_wr_data;

    // Result word
    logic                 r_valid;
    logic                 r_found;
    logic [ID_W-1:0]      r_id;
    logic [HIT_W-1:0]     r_hx;
    logic [HIT_W-1:0]     r_hy;

    t_uword               uw;
    logic                 pick_acc;
    logic                 wr_acc;
    logic                 wr_in_store;
    logic [MW-1:0]        wr_prod;
    logic                 rd_issue;
    logic                 miss;
    logic                 hit;
    logic                 inb;
    logic [COORD_W-1:0]   row;
    logic [MW-1:0]        rd_prod;
    logic [SEGW-1:0]      done_inc;

    assign busy     = r_busy;
    assign uw       = uc_rom(r_step);
    assign pick_acc = start && !r_busy && (i_op == OP_PICK);
    assign wr_acc   = start && !r_busy && (i_op == OP_WRITE);
    assign hit      = r_b_v && r_b_inb && (rd_data != '0);

    // Config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_w <= RST_FRAME_WIDTH;
            r_frame_h <= RST_FRAME_HEIGHT;
            r_mode    <= MODE_LR;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FRAME_WIDTH:  r_frame_w <= i_cfg_data;
                CFG_FRAME_HEIGHT: r_frame_h <= i_cfg_data;
                CFG_SCAN_MODE:    r_mode    <= i_cfg_data[MODE_W-1:0];
                default: ;
            endcase
        end
    end

    // Write address: row-major, drop writes outside the store
    assign wr_in_store = (32'(i_pos_x) < 32'(MAX_WIDTH)) && (32'(i_pos_y) < 32'(MAX_HEIGHT));
    assign wr_prod     = MW'(i_pos_y) * MW'(MAX_WIDTH) + MW'(i_pos_x);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_v <= 1'b0;
        end else begin
            r_wr_v <= wr_acc && wr_in_store;
        end
        r_wr_addr <= wr_prod[AW-1:0];
        r_wr_data <= i_pixel_id;
    end

    // Bounds check and store address of the current point; negative wraps high and fails
    assign inb     = ($unsigned(r_px) < COORD_W'(r_eff_w)) &&
                     ($unsigned(r_py) < COORD_W'(r_eff_h));
    assign row     = COORD_W'(r_eff_h) - COORD_W'(1) - r_py;
    assign rd_prod = MW'(row) * MW'(MAX_WIDTH) + MW'(r_px);
    assign done_inc = r_done + SEGW'(1);

    // Sequencer: action decode and next step
    always_comb begin
        n_busy   = r_busy;
        n_step   = r_step;
        n_mx     = r_mx;
        n_my     = r_my;
        n_eff_w  = r_eff_w;
        n_eff_h  = r_eff_h;
        n_px     = r_px;
        n_py     = r_py;
        n_by     = r_by;
        n_oy     = r_oy;
        n_cnt    = r_cnt;
        n_dx     = r_dx;
        n_dy     = r_dy;
        n_seg    = r_seg;
        n_done   = r_done;
        rd_issue = 1'b0;
        miss     = 1'b0;
        if (pick_acc) begin
            n_busy  = 1'b1;
            n_step  = ST_DISPATCH;
            n_mx    = i_pos_x;
            n_my    = i_pos_y;
            // frame size saturates at the store size
            n_eff_w = (32'(r_frame_w) > 32'(MAX_WIDTH))  ? POS_W'(MAX_WIDTH)  : r_frame_w;
            n_eff_h = (32'(r_frame_h) > 32'(MAX_HEIGHT)) ? POS_W'(MAX_HEIGHT) : r_frame_h;
        end else if (r_busy) begin
            if (hit) begin
                n_busy = 1'b0;
            end else begin
                case (uw.act)
                    ACT_ORG_FWD: begin
                        n_px  = COORD_W'(r_mx);
                        n_py  = COORD_W'(r_my);
                        n_by  = COORD_W'(r_my);
                        n_oy  = '0;
                        n_cnt = '0;
                    end
                    ACT_ORG_BWD: begin
                        n_px  = COORD_W'(r_mx) - COORD_W'(PICK_SIZE);
                        n_py  = COORD_W'(r_my) - COORD_W'(PICK_SIZE);
                        n_by  = COORD_W'(r_my) - COORD_W'(PICK_SIZE);
                        n_oy  = '0;
                        n_cnt = '0;
                    end
                    ACT_ORG_SPI: begin
                        n_px   = COORD_W'(r_mx);
                        n_py   = COORD_W'(r_my);
                        n_dx   = 2'b01;
                        n_dy   = 2'b00;
                        n_seg  = SEGW'(1);
                        n_done = '0;
                        n_cnt  = '0;
                    end
                    ACT_WIN: begin
                        rd_issue = 1'b1;
                        n_cnt    = r_cnt + CNTW'(1);
                        // rows inner, columns outer
                        if (r_oy == LAST_OY) begin
                            n_oy = '0;
                            n_py = r_by;
                            n_px = r_px + COORD_W'(1);
                        end else begin
                            n_oy = r_oy + OYW'(1);
                            n_py = r_py + COORD_W'(1);
                        end
                    end
                    ACT_SPI: begin
                        rd_issue = 1'b1;
                        n_cnt    = r_cnt + CNTW'(1);
                        n_px     = r_px + {{(COORD_W-2){r_dx[1]}}, r_dx};
                        n_py     = r_py + {{(COORD_W-2){r_dy[1]}}, r_dy};
                        n_done   = done_inc;
                        // end of segment: turn left, lengthen after each vertical leg
                        if (done_inc == r_seg) begin
                            n_done = '0;
                            n_dx   = 2'b00 - r_dy;
                            n_dy   = r_dx;
                            if (r_dx == 2'b00) begin
                                n_seg = r_seg + SEGW'(1);
                            end
                        end
                    end
                    ACT_ONE: begin
                        rd_issue = 1'b1;
                    end
                    ACT_MISS: begin
                        miss   = 1'b1;
                        n_busy = 1'b0;
                    end
                    default: ;
                endcase
                case (uw.jmp)
                    JMP_NEXT: n_step = r_step + STEP_W'(1);
                    JMP_LOOP: n_step = (r_cnt == LAST_CNT) ? r_step + STEP_W'(1) : r_step;
                    JMP_GOTO: n_step = uw.target;
                    JMP_MODE: n_step = mode_entry(r_mode);
                    default:  n_step = r_step;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= ST_DISPATCH;
        end else begin
            r_busy <= n_busy;
            r_step <= n_step;
        end
        r_mx    <= n_mx;
        r_my    <= n_my;
        r_eff_w <= n_eff_w;
        r_eff_h <= n_eff_h;
        r_px    <= n_px;
        r_py    <= n_py;
        r_by    <= n_by;
        r_oy    <= n_oy;
        r_cnt   <= n_cnt;
        r_dx    <= n_dx;
        r_dy    <= n_dy;
        r_seg   <= n_seg;
        r_done  <= n_done;
    end

    // Read pipeline; a hit flushes whatever follows it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
        end else begin
            r_a_v <= rd_issue;
            r_b_v <= r_a_v && !hit;
        end
        r_a_inb  <= inb;
        r_a_addr <= rd_prod[AW-1:0];
        r_a_x    <= r_px[HIT_W-1:0];
        r_a_y    <= r_py[HIT_W-1:0];
        r_b_inb  <= r_a_inb;
        r_b_x    <= r_a_x;
        r_b_y    <= r_a_y;
    end

    cip_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (r_wr_v),
        .i_waddr (r_wr_addr),
        .i_wdata (r_wr_data),
        .i_raddr (r_a_addr),
        .o_rdata (rd_data)
    );

    // Result word, one cycle strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= hit || (miss && r_busy);
        end
        r_found <= hit;
        r_id    <= hit ? rd_data : '0;
        r_hx    <= hit ? r_b_x : '0;
        r_hy    <= hit ? r_b_y : '0;
    end

    assign o_valid  = r_valid;
    assign o_found  = r_found;
    assign o_hit_id = r_id;
    assign o_hit_x  = r_hx;
    assign o_hit_y  = r_hy;

    // Checks
    a_res_from_pick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_busy))
        else $error("result word without a pick in progress");

    a_pick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pick_acc |=> (busy && r_step == ST_DISPATCH))
        else $error("accepted pick did not start the program");

    a_read_in_pick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_v || r_b_v) |-> r_busy)
        else $error("store read in flight while idle");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> (o_hit_id == '0 && o_hit_x == '0 && o_hit_y == '0))
        else $error("miss word carries nonzero fields");

    a_hit_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_found) |-> (o_hit_id != '0))
        else $error("hit word with zero ID");

endmodule

### rtl/core/cip_store.sv
// ID frame store: one write port, one read port with registered read data.
module cip_store #(
    parameter int DEPTH = cip_pkg::DEF_MAX_WIDTH * cip_pkg::DEF_MAX_HEIGHT,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [AW-1:0]            i_waddr,
    input  logic [cip_pkg::ID_W-1:0] i_wdata,
    input  logic [AW-1:0]            i_raddr,
    output logic [cip_pkg::ID_W-1:0] o_rdata
);
    import cip_pkg::*;

    logic [ID_W-1:0] r_mem [DEPTH];
    logic [ID_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered read data
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
